@@ rtl/core/phased_pump_profile_controller_assert.svh @@
// Assertion macros for the pump profile controller.
`ifndef PHASED_PUMP_PROFILE_CONTROLLER_ASSERT_SVH
`define PHASED_PUMP_PROFILE_CONTROLLER_ASSERT_SVH
// Assert that a condition implies a consequent in the same cycle.
`define PPPC_ASSERT_IMP(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Assert that a condition implies a consequent in the next cycle.
`define PPPC_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/core/pppc_pkg.sv @@
// Package for the pump profile controller: types, codes and constants.
package pppc_pkg;
    localparam int unsigned CMD_W = 2;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_DONE = 2'd2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [2:0] REG_PH1 = 3'd0;
    localparam logic [2:0] REG_PH2 = 3'd1;
    localparam logic [2:0] REG_PH3 = 3'd2;
    localparam logic [2:0] REG_TGT = 3'd3;
    localparam logic [2:0] REG_STOPF = 3'd4;
    localparam logic [2:0] REG_EMA = 3'd5;
    localparam logic [2:0] REG_IVAL = 3'd6;
    localparam logic [2:0] REG_DRIP = 3'd7;
    localparam int unsigned CFG_DATA_W = 59;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic signed [15:0] weight;
        logic signed [15:0] raw_weight;
    } t_in_word;

    typedef struct packed {
        logic [6:0]  pump_level;
        logic [9:0]  target_power;
        logic [9:0]  target_flow;
        logic [15:0] flow_rate;
        logic [1:0]  phase;
        logic [1:0]  mode;
        logic        shot_finished;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_word;

    typedef enum logic [3:0] {
        S_IDLE, S_CMD, S_FLOW_CHK, S_FLOW_DIV, S_FLOW_EMA, S_STOP_CHK,
        S_RAMP_MUL, S_RAMP_DIV, S_PHASE, S_DRIP, S_OUT
    } t_state;
endpackage

@@ rtl/core/pppc_if.sv @@
// Valid/ready stream interface carrying one word of a given type.
interface pppc_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/pppc_divider.sv @@
// Shared restoring divider, one quotient bit per cycle, 40 by 32 bits.
module pppc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [39:0] o_quot
);
    logic [39:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_den;
    logic [32:0] w_sh;

    // Shift in the next numerator bit and try a subtract.
    always_comb begin
        w_sh = {r_rem[31:0], r_q[39]};
        n_q = {r_q[38:0], 1'b0};
        n_rem = w_sh;
        n_cnt = r_cnt;
        if (r_cnt != 6'd0) begin
            n_cnt = r_cnt - 6'd1;
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q[0] = 1'b1;
            end
        end else begin
            n_q = r_q;
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd40;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else begin
            r_q <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_q;
endmodule

@@ rtl/core/phased_pump_profile_controller.sv @@
// Top level of the phased pump profile controller.
// A command word is accepted only while the sequencer is idle. Its result word is
// loaded into the output register once the sequencer has run through its command,
// flow check, filter, stop test and phase or drip steps. The longest case is set by
// two passes through one shared 40-bit restoring divider (one quotient bit per
// cycle). The first pass is for the instant flow and the second for the ramp target.
// A word that has no flow update due and no ramp left to divide skips the divider.
// The block accepts no new word until the result is loaded into the output register;
// a result waiting there does not stop the next word from being taken. Configuration
// writes are taken at any time and should be issued only while the block is idle.
module phased_pump_profile_controller (
    input  logic i_clk,
    input  logic i_rst_n,
    pppc_if.sink   in_ch,
    pppc_if.source out_ch,
    pppc_if.sink   cfg_ch
);
    import pppc_pkg::*;
    `include "phased_pump_profile_controller_assert.svh"

    // Configuration registers.
    logic [58:0] r_ph [3];
    logic [14:0] r_tgt;
    logic [11:0] r_stopf;
    logic [8:0]  r_ema;
    logic [15:0] r_ival;
    logic [15:0] r_drip;

    // Controller state.
    logic [1:0]  r_mode, n_mode;
    logic [1:0]  r_phnum, n_phnum;
    logic [31:0] r_phase_start, n_phase_start;
    logic [31:0] r_last_flow, n_last_flow;
    logic signed [15:0] r_last_raw, n_last_raw;
    logic [15:0] r_flow, n_flow;
    logic [6:0]  r_pump, n_pump;
    logic [31:0] r_done_start, n_done_start;

    // Per-word working registers.
    t_state      r_st, n_st;
    t_in_word    r_in;
    logic [29:0] r_inst, n_inst;
    logic [9:0]  r_tp, n_tp, r_tf, n_tf, r_t, n_t;
    logic        r_fin, n_fin, r_stopped, n_stopped;
    logic        r_ovalid;
    t_out_word   r_out;

    // Divider hookup.
    logic        w_dstart, w_dbusy;
    logic [39:0] w_dnum, w_dquot;
    logic [31:0] w_dden;

    pppc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_busy(w_dbusy), .o_quot(w_dquot)
    );

    // Decode helpers.
    logic [58:0] w_pw;
    logic [9:0]  w_s, w_e;
    logic [18:0] w_r;
    logic [14:0] w_xw;
    logic [10:0] w_xt;
    logic        w_fmode;
    logic [31:0] w_el, w_dt, w_ivn;
    logic [9:0]  w_diff;
    logic signed [16:0] w_rdiff;
    logic [8:0]  w_a;
    logic [39:0] w_ema_acc;
    logic signed [34:0] w_lhs, w_rhs;
    logic [13:0] w_goal;
    logic [17:0] w_tq_mul;
    logic [9:0]  w_tq;

    always_comb begin
        w_pw = r_ph[r_phnum - 2'd1];
        w_s = w_pw[9:0];
        w_e = w_pw[19:10];
        w_r = 19'(w_pw[31:20]) * 19'd100;
        w_xw = w_pw[46:32];
        w_xt = w_pw[57:47];
        w_fmode = w_pw[58] && (r_phnum != 2'd1);
        w_el = r_in.now_ms - r_phase_start;
        w_dt = r_in.now_ms - r_last_flow;
        w_ivn = (r_ival == 16'd0) ? 32'd1 : 32'(r_ival);
        w_diff = (w_e >= w_s) ? (w_e - w_s) : (w_s - w_e);
        w_rdiff = 17'(r_in.raw_weight) - 17'(r_last_raw);
        w_a = (r_ema > 9'd256) ? 9'd256 : r_ema;
        w_ema_acc = (40'(r_flow) * 40'(9'd256 - w_a) +
                     40'(r_inst) * 40'(w_a)) >> 8;
        w_lhs = 35'(r_in.weight) * 35'sd5120;
        w_rhs = 35'(r_tgt) * 35'sd5120 - 35'(r_flow) * 35'(r_stopf);
        w_goal = 14'(r_t) * 14'd10;
        // Divide the target by 10 with a reciprocal multiply, exact below 1029.
        w_tq_mul = 18'(r_t) * 18'd205;
        w_tq = 10'(w_tq_mul >> 11);
    end

    // Sequencer next state and datapath updates.
    always_comb begin
        n_st = r_st;
        n_mode = r_mode; n_phnum = r_phnum; n_phase_start = r_phase_start;
        n_last_flow = r_last_flow; n_last_raw = r_last_raw; n_flow = r_flow;
        n_pump = r_pump; n_done_start = r_done_start;
        n_inst = r_inst; n_tp = r_tp; n_tf = r_tf; n_t = r_t;
        n_fin = r_fin; n_stopped = r_stopped;
        w_dstart = 1'b0;
        w_dnum = '0;
        w_dden = 32'd1;
        case (r_st)
            S_IDLE: begin
                if (in_ch.valid) n_st = S_CMD;
            end
            S_CMD: begin
                n_tp = '0; n_tf = '0; n_fin = 1'b0; n_stopped = 1'b0;
                if (r_in.cmd == CMD_START && r_mode == MODE_IDLE) begin
                    n_mode = MODE_EXTRACT; n_phnum = 2'd1;
                    n_phase_start = r_in.now_ms; n_last_flow = r_in.now_ms;
                    n_last_raw = '0; n_flow = '0;
                end else if (r_in.cmd == CMD_STOP && r_mode == MODE_EXTRACT) begin
                    n_mode = MODE_DONE; n_done_start = r_in.now_ms;
                end else if (r_in.cmd == CMD_STOP && r_mode == MODE_DONE) begin
                    n_mode = MODE_IDLE; n_fin = 1'b1;
                end
                n_st = S_FLOW_CHK;
            end
            S_FLOW_CHK: begin
                if (r_mode == MODE_IDLE || w_dt < w_ivn) begin
                    n_st = S_STOP_CHK;
                end else if (w_rdiff > 17'sd0) begin
                    w_dstart = 1'b1;
                    w_dnum = 40'(w_rdiff[16:0]) * 40'd10000;
                    w_dden = w_dt;
                    n_st = S_FLOW_DIV;
                end else begin
                    n_inst = '0;
                    n_st = S_FLOW_EMA;
                end
            end
            S_FLOW_DIV: begin
                // The instant flow stays below 2^30, so keep it whole.
                if (!w_dbusy) begin
                    n_inst = w_dquot[29:0];
                    n_st = S_FLOW_EMA;
                end
            end
            S_FLOW_EMA: begin
                n_flow = (w_ema_acc > 40'd65535) ? 16'hFFFF : w_ema_acc[15:0];
                n_last_raw = r_in.raw_weight;
                n_last_flow = r_in.now_ms;
                n_st = S_STOP_CHK;
            end
            S_STOP_CHK: begin
                if (r_mode == MODE_EXTRACT) begin
                    if (w_lhs >= w_rhs) begin
                        n_mode = MODE_DONE; n_done_start = r_in.now_ms;
                        n_stopped = 1'b1;
                        n_st = S_OUT;
                    end else if (r_phnum == 2'd0) begin
                        n_st = S_OUT;
                    end else begin
                        n_st = S_RAMP_MUL;
                    end
                end else begin
                    n_st = S_DRIP;
                end
            end
            S_RAMP_MUL: begin
                if (w_r == 19'd0 || w_el >= 32'(w_r)) begin
                    n_t = w_e;
                    n_st = S_PHASE;
                end else begin
                    w_dstart = 1'b1;
                    w_dnum = 40'(w_diff) * 40'(w_el[18:0]);
                    w_dden = 32'(w_r);
                    n_st = S_RAMP_DIV;
                end
            end
            S_RAMP_DIV: begin
                if (!w_dbusy) begin
                    n_t = (w_e >= w_s) ? (w_s + w_dquot[9:0]) : (w_s - w_dquot[9:0]);
                    n_st = S_PHASE;
                end
            end
            S_PHASE: begin
                if (w_fmode) begin
                    n_tf = r_t;
                    if (r_flow < 16'(w_goal)) begin
                        n_pump = (r_pump + 7'd2 > 7'd100) ? 7'd100 : r_pump + 7'd2;
                    end else if (r_flow > 16'(w_goal)) begin
                        n_pump = (r_pump < 7'd3) ? 7'd1 : r_pump - 7'd2;
                    end
                end else begin
                    n_tp = r_t;
                    n_pump = (w_tq > 10'd100) ? 7'd100 : w_tq[6:0];
                end
                if (r_phnum != 2'd3 && (r_in.weight >= $signed({1'b0, w_xw}) ||
                        (w_xt != 11'd0 && w_el >= 32'(w_xt) * 32'd100))) begin
                    n_phnum = r_phnum + 2'd1;
                    n_phase_start = r_in.now_ms;
                end
                n_st = S_OUT;
            end
            S_DRIP: begin
                if (r_mode == MODE_DONE && !r_stopped &&
                        r_in.now_ms - r_done_start >= 32'(r_drip)) begin
                    n_mode = MODE_IDLE; n_fin = 1'b1;
                end
                n_st = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || out_ch.ready) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        in_ch.ready = (r_st == S_IDLE);
        cfg_ch.ready = 1'b1;
        out_ch.valid = r_ovalid;
        out_ch.data = r_out;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_mode <= MODE_IDLE; r_phnum <= '0;
            r_phase_start <= '0; r_last_flow <= '0; r_last_raw <= '0;
            r_flow <= '0; r_pump <= '0; r_done_start <= '0; r_ovalid <= 1'b0;
            r_ph[0] <= '0; r_ph[1] <= '0; r_ph[2] <= '0;
            r_tgt <= 15'd360; r_stopf <= 12'd256; r_ema <= 9'd64;
            r_ival <= 16'd100; r_drip <= 16'd3000;
        end else begin
            r_st <= n_st; r_mode <= n_mode; r_phnum <= n_phnum;
            r_phase_start <= n_phase_start; r_last_flow <= n_last_flow;
            r_last_raw <= n_last_raw; r_flow <= n_flow; r_pump <= n_pump;
            r_done_start <= n_done_start;
            if (r_st == S_OUT && (!r_ovalid || out_ch.ready)) begin
                r_ovalid <= 1'b1;
            end else if (out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_ch.valid) begin
                case (cfg_ch.data.index)
                    REG_PH1: r_ph[0] <= cfg_ch.data.data;
                    REG_PH2: r_ph[1] <= cfg_ch.data.data;
                    REG_PH3: r_ph[2] <= cfg_ch.data.data;
                    REG_TGT: r_tgt <= cfg_ch.data.data[14:0];
                    REG_STOPF: r_stopf <= cfg_ch.data.data[11:0];
                    REG_EMA: r_ema <= cfg_ch.data.data[8:0];
                    REG_IVAL: r_ival <= cfg_ch.data.data[15:0];
                    REG_DRIP: r_drip <= cfg_ch.data.data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && in_ch.valid) r_in <= in_ch.data;
        r_inst <= n_inst; r_tp <= n_tp; r_tf <= n_tf; r_t <= n_t;
        r_fin <= n_fin; r_stopped <= n_stopped;
        if (r_st == S_OUT && (!r_ovalid || out_ch.ready)) begin
            r_out.pump_level <= (r_mode == MODE_EXTRACT) ? r_pump : 7'd0;
            r_out.target_power <= (r_mode == MODE_EXTRACT) ? r_tp : 10'd0;
            r_out.target_flow <= (r_mode == MODE_EXTRACT) ? r_tf : 10'd0;
            r_out.flow_rate <= r_flow;
            r_out.phase <= (r_mode == MODE_EXTRACT) ? r_phnum : 2'd0;
            r_out.mode <= r_mode;
            r_out.shot_finished <= r_fin;
        end
    end

    `PPPC_ASSERT_IMP(a_ready_idle, in_ch.ready, r_st == S_IDLE, "ready outside idle")
    `PPPC_ASSERT_NEXT(a_accept_cmd, in_ch.valid && in_ch.ready, r_st == S_CMD, "no cmd step")
    `PPPC_ASSERT_IMP(a_pump_range, r_mode == MODE_EXTRACT, r_pump <= 7'd100, "pump above 100")
    `PPPC_ASSERT_IMP(a_phase_ext, r_mode == MODE_EXTRACT && r_st == S_IDLE,
        r_phnum != 2'd0, "phase zero while extracting")
endmodule
